// ----- hdl/rgb_macro_line_parser_macros.svh -----
// Assertion macros shared by the RGB macro line parser modules.
`ifndef RGB_MACRO_LINE_PARSER_MACROS_SVH
`define RGB_MACRO_LINE_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RMLP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmlp assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RMLP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmlp assertion failed");

`endif

// ----- hdl/rmlp_pkg.sv -----
// Shared types and constants for the RGB macro line parser.
package rmlp_pkg;

    // Default depth of the queue between the classifier and the executor.
    localparam int QUEUE_DEPTH_DEF = 4;

    // One classified text byte as it travels from the front to the back.
    typedef struct packed {
        logic       newline;
        logic       semicolon;
        logic       dollar;
        logic       dec_digit;
        logic       hex_digit;
        logic [3:0] digit;
        logic       letter_r;
        logic       letter_g;
        logic       letter_b;
        logic       last;
    } beat_t;

endpackage

// ----- hdl/rmlp_front.sv -----
// Front end: accept text bytes and classify them into beats.
module rmlp_front
    import rmlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    output logic       beat_valid,
    input  logic       beat_stall,
    output beat_t      beat
);

    logic       valid_reg;
    logic       valid_next;
    beat_t      beat_reg;
    beat_t      class_next;
    logic [7:0] upper;
    logic       accept;

    always_comb
    begin
        upper = ((text_byte >= 8'h61) && (text_byte <= 8'h7A)) ? (text_byte - 8'd32)
                                                              : text_byte;
        class_next.newline   = (text_byte == 8'h0A);
        class_next.semicolon = (text_byte == 8'h3B);
        class_next.dollar    = (text_byte == 8'h24);
        class_next.dec_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
        class_next.hex_digit = class_next.dec_digit ||
                               ((upper >= 8'h41) && (upper <= 8'h46));
        // letters a-f and A-F share a low nibble of 1..6
        class_next.digit     = class_next.dec_digit ? text_byte[3:0]
                                                    : (text_byte[3:0] + 4'd9);
        class_next.letter_r  = (upper == 8'h52);
        class_next.letter_g  = (upper == 8'h47);
        class_next.letter_b  = (upper == 8'h42);
        class_next.last      = last_byte;
    end

    assign in_stall   = valid_reg && beat_stall;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept ? 1'b1 : (valid_reg && beat_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= class_next;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ----- hdl/rmlp_queue.sv -----
// Short beat queue that decouples the classifier from the executor.
module rmlp_queue
    import rmlp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_stall,
    input  beat_t push_beat,
    output logic  pop_valid,
    input  logic  pop_take,
    output beat_t pop_beat
);

    `include "rgb_macro_line_parser_macros.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    beat_t         store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign push_stall = (count_reg == CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && !push_stall;
    assign pop        = pop_take && pop_valid;
    assign pop_beat   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : (wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : (rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_beat;
        end
    end

    `RMLP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `RMLP_ASSERT_NEXT(a_push_fills, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `RMLP_ASSERT_NOW(a_ptr_gap, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

// ----- hdl/rmlp_exec.sv -----
// Back end: run the line parser on classified beats and register results.
module rmlp_exec
    import rmlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat_valid,
    output logic       beat_take,
    input  beat_t      beat,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       color_valid,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic       end_of_text,
    output logic       any_found
);

    `include "rgb_macro_line_parser_macros.svh"

    localparam logic [1:0] MATCH_NONE = 2'd0;
    localparam logic [1:0] MATCH_R    = 2'd1;
    localparam logic [1:0] MATCH_RG   = 2'd2;

    localparam logic [1:0] NUM_NONE = 2'd0;
    localparam logic [1:0] NUM_DEC  = 2'd1;
    localparam logic [1:0] NUM_HEX  = 2'd2;

    localparam logic [1:0] CHANNELS = 2'd3;

    typedef struct packed {
        logic            in_comment;
        logic            token_found;
        logic [1:0]      match_stage;
        logic [1:0]      number_mode;
        logic            hex_has_digit;
        logic [4:0]      accumulator;
        logic [1:0]      value_count;
        logic [2:0][4:0] channel_values;
    } line_t;

    localparam line_t LINE_CLEAR = '0;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    // close the open number, keeping it if it holds a value
    function automatic line_t finish_number(input line_t s);
        line_t r;
        r = s;
        if (((s.number_mode == NUM_DEC) ||
             ((s.number_mode == NUM_HEX) && s.hex_has_digit)) &&
            (s.value_count < CHANNELS))
        begin
            r.channel_values[s.value_count] = s.accumulator;
            r.value_count = s.value_count + 1'b1;
        end
        r.number_mode   = NUM_NONE;
        r.hex_has_digit = 1'b0;
        r.accumulator   = '0;
        return r;
    endfunction

    function automatic line_t value_byte(input line_t s, input beat_t b);
        line_t r;
        logic  fresh;
        r     = s;
        fresh = 1'b1;
        unique case (s.number_mode)
            NUM_DEC:
            begin
                if (b.dec_digit)
                begin
                    // acc * 10 + d, modulo 32
                    r.accumulator = {s.accumulator[1:0], 3'b000} +
                                    {s.accumulator[3:0], 1'b0} + {1'b0, b.digit};
                    fresh = 1'b0;
                end
                else
                begin
                    r = finish_number(s);
                end
            end
            NUM_HEX:
            begin
                if (b.hex_digit)
                begin
                    r.accumulator   = {s.accumulator[0], b.digit};
                    r.hex_has_digit = 1'b1;
                    fresh = 1'b0;
                end
                else
                begin
                    r = finish_number(s);
                end
            end
            default:
            begin
                r.number_mode = NUM_NONE;
            end
        endcase
        if (fresh && (r.value_count < CHANNELS))
        begin
            if (b.dollar)
            begin
                r.number_mode   = NUM_HEX;
                r.accumulator   = '0;
                r.hex_has_digit = 1'b0;
            end
            else if (b.dec_digit)
            begin
                r.number_mode = NUM_DEC;
                r.accumulator = {1'b0, b.digit};
            end
        end
        return r;
    endfunction

    function automatic line_t match_byte(input line_t s, input beat_t b);
        line_t r;
        r = s;
        if ((s.match_stage == MATCH_R) && b.letter_g)
        begin
            r.match_stage = MATCH_RG;
        end
        else if ((s.match_stage == MATCH_RG) && b.letter_b)
        begin
            r.token_found = 1'b1;
            r.match_stage = MATCH_NONE;
        end
        else
        begin
            r.match_stage = b.letter_r ? MATCH_R : MATCH_NONE;
        end
        return r;
    endfunction

    line_t      line_reg;
    line_t      line_next;
    line_t      work;
    logic       seen_reg;
    logic       seen_next;
    logic       seen_now;
    logic       emit;
    logic       triple;
    logic       take;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       color_valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic       end_of_text_reg;
    logic       any_found_reg;

    always_comb
    begin
        work = line_reg;
        if (!beat.newline)
        begin
            if (line_reg.in_comment)
            begin
                work = line_reg;
            end
            else if (beat.semicolon)
            begin
                if (line_reg.token_found && (line_reg.value_count < CHANNELS))
                begin
                    work = finish_number(line_reg);
                end
                work.in_comment = 1'b1;
            end
            else if (!line_reg.token_found)
            begin
                work = match_byte(line_reg, beat);
            end
            else if (line_reg.value_count < CHANNELS)
            begin
                work = value_byte(line_reg, beat);
            end
        end

        triple    = 1'b0;
        emit      = 1'b0;
        seen_now  = seen_reg;
        seen_next = seen_reg;
        line_next = work;
        if (beat.newline || beat.last)
        begin
            if (work.token_found && (work.value_count < CHANNELS))
            begin
                work = finish_number(work);
            end
            triple    = (work.value_count == CHANNELS);
            seen_now  = seen_reg || triple;
            seen_next = seen_now && !beat.last;
            emit      = triple || beat.last;
            line_next = LINE_CLEAR;
        end
    end

    // take beats that give no result even while the output register is full
    assign take = beat_valid && (!emit || !out_valid_reg || !out_stall);
    assign beat_take = take;
    assign out_valid_next = (take && emit) ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= LINE_CLEAR;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                line_reg <= line_next;
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            color_valid_reg <= triple;
            red_reg         <= triple ? expand5(work.channel_values[0]) : 8'd0;
            green_reg       <= triple ? expand5(work.channel_values[1]) : 8'd0;
            blue_reg        <= triple ? expand5(work.channel_values[2]) : 8'd0;
            end_of_text_reg <= beat.last;
            any_found_reg   <= seen_now;
        end
    end

    assign out_valid   = out_valid_reg;
    assign color_valid = color_valid_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign end_of_text = end_of_text_reg;
    assign any_found   = any_found_reg;

    `RMLP_ASSERT_NOW(a_blank_is_final, out_valid_reg && !color_valid_reg, end_of_text_reg)
    `RMLP_ASSERT_NOW(a_colour_counts, out_valid_reg && color_valid_reg, any_found_reg)
    `RMLP_ASSERT_NOW(a_full_no_number, line_reg.value_count == CHANNELS,
        line_reg.number_mode == NUM_NONE)
    `RMLP_ASSERT_NEXT(a_final_clears, take && beat.last, !seen_reg && !line_reg.token_found)

endmodule

// ----- hdl/rgb_macro_line_parser.sv -----
// Top level of the RGB macro line parser: front end, beat queue and executor.
//
// The parser takes palette source text one byte per beat and reports one
// colour for each line that holds the token RGB (any letter case) followed
// by three numbers, written in decimal or as $hex; everything from a
// semicolon to the end of the line is ignored, and each value keeps its low
// five bits before it is widened to eight by bit replication. A result beat
// leaves for every such line and always for the byte flagged last_byte, with
// color_valid low when that final line holds no colour; any_found tells
// whether the text has given at least one colour, and all state clears after
// the final byte. Throughput is one byte per clock while nothing stalls: the
// classifier registers each byte as a beat, the queue holds up to QUEUE_DEPTH
// beats, and the executor updates its line state once per beat. An accepted
// byte is registered as a beat in the front end, then written into the queue
// store, then into the result register. The queue lets the front keep taking
// bytes while out_stall holds a result back, and bytes that give no result keep
// draining the queue even while a finished result waits to be taken.
module rgb_macro_line_parser
    import rmlp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       color_valid,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic       end_of_text,
    output logic       any_found
);

    // classified beat from the front end into the queue
    logic  front_valid;
    logic  front_stall;
    beat_t front_beat;

    // queue head towards the executor
    logic  head_valid;
    logic  head_take;
    beat_t head_beat;

    rmlp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .last_byte  (last_byte),
        .beat_valid (front_valid),
        .beat_stall (front_stall),
        .beat       (front_beat)
    );

    rmlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_stall (front_stall),
        .push_beat  (front_beat),
        .pop_valid  (head_valid),
        .pop_take   (head_take),
        .pop_beat   (head_beat)
    );

    rmlp_exec u_exec
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_valid  (head_valid),
        .beat_take   (head_take),
        .beat        (head_beat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color_valid (color_valid),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .end_of_text (end_of_text),
        .any_found   (any_found)
    );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the RGB macro line parser: directed lines, then random palette texts.
module tb_top;

    // Character codes the parser reacts to
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_DOLLAR = "$";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_9      = "9";
    localparam logic [7:0] CH_UA     = "A";
    localparam logic [7:0] CH_UF     = "F";
    localparam logic [7:0] CH_LA     = "a";
    localparam logic [7:0] CH_LF     = "f";
    localparam logic [7:0] CH_LZ     = "z";
    localparam logic [7:0] CH_R      = "R";
    localparam logic [7:0] CH_G      = "G";
    localparam logic [7:0] CH_B      = "B";
    localparam logic [7:0] CH_HIGH   = 8'hFF;

    // Letters of the token matched so far
    localparam logic [1:0] LET_NONE = 2'd0;
    localparam logic [1:0] LET_R    = 2'd1;
    localparam logic [1:0] LET_RG   = 2'd2;

    localparam int CASE_GAP     = 32;   // distance from lower to upper case
    localparam int DEC_BASE     = 10;
    localparam int HEX_BASE     = 16;
    localparam int HEX_ALPHA    = 'hA;  // value of the hex digit A
    localparam int RANDOM_BYTES = 600;
    localparam int IDLE_LIMIT   = 2000; // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 12;   // settling time after every owed colour has left

    typedef enum logic [1:0] {NUM_NONE, NUM_DEC, NUM_HEX} num_kind_e;

    // Line state of the predictor
    typedef struct {
        logic            in_cmt;
        logic            tok;
        logic [1:0]      letters;
        num_kind_e       kind;
        logic            hex_seen;
        logic [4:0]      acc;
        logic [1:0]      nvals;
        logic [2:0][4:0] chan;
        logic            any_colour;
    } line_state_t;

    // One result beat as the parser should give it
    typedef struct packed {
        logic       cv;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       eot;
        logic       any;
    } colour_beat_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] text_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       color_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_text;
    logic       any_found;

    line_state_t  line_st;
    colour_beat_t colour_q[$];   // colours still owed by the parser
    logic [7:0]   text_q[$];     // text being assembled for the next send
    int           errors     = 0;
    int           idle_count = 0;
    int           stall_left = 0;
    bit           pace_on    = 1'b0;

    rgb_macro_line_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color_valid (color_valid),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .end_of_text (end_of_text),
        .any_found   (any_found)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Widen a 5-bit channel to 8 bits by replicating its top bits
    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    // Drop everything the current line has gathered; the colour-seen flag
    // belongs to the whole text and stays
    function automatic void clear_line_state();
        line_st.in_cmt   = 1'b0;
        line_st.tok      = 1'b0;
        line_st.letters  = LET_NONE;
        line_st.kind     = NUM_NONE;
        line_st.hex_seen = 1'b0;
        line_st.acc      = 5'd0;
        line_st.nvals    = 2'd0;
        line_st.chan     = '0;
    endfunction

    // End the number in progress; a lone dollar gives no value
    function automatic void close_number();
        if (line_st.kind == NUM_DEC || (line_st.kind == NUM_HEX && line_st.hex_seen))
        begin
            if (line_st.nvals < 3)
            begin
                line_st.chan[line_st.nvals] = line_st.acc;
                line_st.nvals++;
            end
        end
        line_st.kind     = NUM_NONE;
        line_st.hex_seen = 1'b0;
        line_st.acc      = 5'd0;
    endfunction

    // Advance the line state by one text byte; return 1 with the expected
    // beat when this byte must give a result
    function automatic bit predict_colour(input logic [7:0] c, input logic at_end,
                                          output colour_beat_t res);
        logic [7:0] up;
        int         hval;
        bit         taken;
        bit         got;
        res   = '0;
        taken = 1'b0;
        if (c != CH_NL)
        begin
            if (line_st.in_cmt)
            begin
                // rest of the line is a comment
            end
            else if (c == CH_SEMI)
            begin
                if (line_st.tok && line_st.nvals < 3)
                    close_number();
                line_st.in_cmt = 1'b1;
            end
            else if (!line_st.tok)
            begin
                up = (c >= CH_LA && c <= CH_LZ) ? 8'(c - CASE_GAP) : c;
                if (line_st.letters == LET_R && up == CH_G)
                    line_st.letters = LET_RG;
                else if (line_st.letters == LET_RG && up == CH_B)
                begin
                    line_st.tok     = 1'b1;
                    line_st.letters = LET_NONE;
                end
                else
                    line_st.letters = (up == CH_R) ? LET_R : LET_NONE;
            end
            else if (line_st.nvals < 3)
            begin
                hval = -1;
                if (c >= CH_0 && c <= CH_9)
                    hval = c - CH_0;
                else if (c >= CH_LA && c <= CH_LF)
                    hval = c - CH_LA + HEX_ALPHA;
                else if (c >= CH_UA && c <= CH_UF)
                    hval = c - CH_UA + HEX_ALPHA;
                if (line_st.kind == NUM_DEC && hval >= 0 && hval < DEC_BASE)
                begin
                    line_st.acc = 5'(line_st.acc * DEC_BASE + hval);
                    taken = 1'b1;
                end
                else if (line_st.kind == NUM_HEX && hval >= 0)
                begin
                    line_st.acc      = 5'(line_st.acc * HEX_BASE + hval);
                    line_st.hex_seen = 1'b1;
                    taken = 1'b1;
                end
                else
                    close_number();
                // the byte that ended a number is taken afresh
                if (!taken && line_st.nvals < 3)
                begin
                    if (c == CH_DOLLAR)
                    begin
                        line_st.kind     = NUM_HEX;
                        line_st.acc      = 5'd0;
                        line_st.hex_seen = 1'b0;
                    end
                    else if (hval >= 0 && hval < DEC_BASE)
                    begin
                        line_st.kind = NUM_DEC;
                        line_st.acc  = 5'(hval);
                    end
                end
            end
        end

        if (!(c == CH_NL || at_end))
            return 1'b0;

        if (line_st.tok && line_st.nvals < 3)
            close_number();
        got = (line_st.nvals == 3);
        if (got)
            line_st.any_colour = 1'b1;
        if (!got && !at_end)
        begin
            clear_line_state();
            return 1'b0;
        end
        res.cv = got;
        if (got)
        begin
            res.r = widen5(line_st.chan[0]);
            res.g = widen5(line_st.chan[1]);
            res.b = widen5(line_st.chan[2]);
        end
        res.eot = at_end;
        res.any = line_st.any_colour;
        clear_line_state();
        if (at_end)
            line_st.any_colour = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Pacing and stimulus helpers
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [7:0] pick_case(input logic [7:0] upper);
        return $urandom_range(0, 1) ? upper : 8'(upper + CASE_GAP);
    endfunction

    // Any byte but a newline, so that noise stays within its line
    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CH_NL) ? CH_HIGH : b;
    endfunction

    function automatic logic [7:0] rand_hex_digit();
        int d;
        d = $urandom_range(0, HEX_BASE - 1);
        return (d < DEC_BASE) ? 8'(CH_0 + d) : pick_case(8'(CH_UA + d - HEX_ALPHA));
    endfunction

    // Append one byte to the text being assembled
    function automatic void put_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endfunction

    // Append one line: mostly a token with three numbers, sometimes a
    // broken token, a wrong count, a trailing comment or plain noise
    function automatic void make_line(input bit last_line);
        int kind_r;
        int nnum;
        int r;
        kind_r = $urandom_range(0, 99);
        if (kind_r < 12)
        begin
            repeat ($urandom_range(0, 8))
                put_byte(rand_text_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                put_byte(CH_SPACE);
            if (kind_r < 24)
                put_byte(pick_case(CH_R));
            put_byte(pick_case(CH_R));
            put_byte(pick_case(CH_G));
            if (kind_r >= 18)
                put_byte(pick_case(CH_B));
            nnum = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 3;
            for (int i = 0; i < nnum; i++)
            begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: put_byte(CH_COMMA);
                    2: put_byte(CH_SPACE);
                    default:
                    begin
                        put_byte(CH_COMMA);
                        put_byte(CH_SPACE);
                    end
                endcase
                r = $urandom_range(0, 99);
                if (r < 5)
                    put_byte(CH_DOLLAR);
                else if (r < 50)
                begin
                    repeat ((r < 10) ? 5 : $urandom_range(1, 3))
                        put_byte(8'(CH_0 + $urandom_range(0, 9)));
                end
                else
                begin
                    put_byte(CH_DOLLAR);
                    repeat ($urandom_range(1, 3))
                        put_byte(rand_hex_digit());
                end
            end
            if ($urandom_range(0, 4) == 0)
            begin
                put_byte(CH_SEMI);
                repeat ($urandom_range(0, 5))
                    put_byte(rand_text_byte());
            end
        end
        if (!last_line || $urandom_range(0, 1))
            put_byte(CH_NL);
    endfunction

    // Offer one byte, hold it until the parser takes it, then record what
    // it should give. Valid is left high so back-to-back beats stay gapless.
    task automatic send_byte(input logic [7:0] c, input logic at_end);
        int           gap;
        colour_beat_t want;
        gap = pace_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= c;
        last_byte <= at_end;
        do
            @(posedge clk);
        while (in_stall);
        if (predict_colour(c, at_end, want))
            colour_q.insert(colour_q.size(), want);
    endtask

    // Send the assembled text; flag its final byte only when the text closes
    task automatic send_text(input bit close_text);
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], close_text && (i == text_q.size() - 1));
        text_q.delete();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One line packing mixed-case token, an overflowing decimal, a number
    // ended by a dollar, a lone dollar and a number ended by a semicolon
    task automatic test_packed_line();
        pace_on = 1'b0;
        add_str("rGb 40$1f$,0;9\n");
        send_text(1'b0);
    endtask

    // Close a text on a non-newline byte with a fourth number and a high
    // byte, then a text of one bare newline that holds no colour
    task automatic test_text_end();
        pace_on = 1'b0;
        add_str("RGB1,2,3,4");
        put_byte(CH_HIGH);
        send_text(1'b1);
        put_byte(CH_NL);
        send_text(1'b1);
    endtask

    // Random texts of several lines, idling on most of them
    task automatic test_random_texts();
        int sent;
        int n_lines;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            pace_on = ($urandom_range(0, 4) != 0);
            n_lines = $urandom_range(1, 6);
            for (int i = 0; i < n_lines; i++)
                make_line(i == n_lines - 1);
            if (text_q.size() == 0)
                put_byte(CH_NL);
            sent += text_q.size();
            send_text(1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, checking, watchdog
    // ------------------------------------------------------------------

    // Hold stall for a picked number of cycles, then pick again
    always @(posedge clk)
    begin : stall_gen
        int n;
        if (stall_left > 1)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else
        begin
            n = pace_on ? pick_gap() : 0;
            stall_left <= n;
            out_stall  <= (n != 0);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each result beat with the oldest colour owed
    always @(posedge clk)
    begin : result_check
        colour_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (colour_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected", $time);
                errors++;
            end
            else
            begin
                want = colour_q.pop_front();
                check_field("color_valid", 8'(want.cv), 8'(color_valid));
                check_field("red", want.r, red);
                check_field("green", want.g, green);
                check_field("blue", want.b, blue);
                check_field("end_of_text", 8'(want.eot), 8'(end_of_text));
                check_field("any_found", 8'(want.any), 8'(any_found));
            end
        end
    end

    // End the run if no beat moves on either side for too long
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        clear_line_state();
        line_st.any_colour = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_packed_line();
        test_text_end();
        test_random_texts();

        // drop valid, wait for every owed colour, then let the pipe settle
        in_valid <= 1'b0;
        pace_on = 1'b0;
        while (colour_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/rmlp_pkg.sv
hdl/rmlp_front.sv
hdl/rmlp_queue.sv
hdl/rmlp_exec.sv
hdl/rgb_macro_line_parser.sv
bench/tb_top.sv
